FILE: hw/rtl/clsu_pkg.sv
// ----------------------------------------------------------------------------
// Command line splitter package
// Shared types and constants for the front classifier and the back emitter.
// ----------------------------------------------------------------------------
package clsu_pkg;

	localparam int RUN_W = 15;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_ARG  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	localparam logic [20:0] CH_TAB    = 21'h09;
	localparam logic [20:0] CH_SPACE  = 21'h20;
	localparam logic [20:0] CH_QUOTE  = 21'h22;
	localparam logic [20:0] CH_BSLASH = 21'h5c;

	localparam logic [5:0] SUR_HI = 6'h36;
	localparam logic [5:0] SUR_LO = 6'h37;

	// One queued operation: an optional backslash run, up to six encoded
	// bytes, and optional argument and line ends after them.
	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic             run_en;
		logic [2:0]       nbytes;
		logic [47:0]      bytes;
		logic             arg_end;
		logic             line_end;
		logic [14:0]      count;
	} op_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data_byte;
		logic [RUN_W-1:0] repeat_res;
		logic [14:0]      arg_count;
		logic             last;
	} res_t;

	function automatic logic [34:0] utf8_encode(input logic [20:0] c);
		logic [2:0]  n;
		logic [31:0] b;
		n = 3'd0;
		b = '0;
		if (c < 21'h80) begin
			n = 3'd1;
			b[7:0] = c[7:0];
		end else if (c < 21'h800) begin
			n = 3'd2;
			b[7:0]  = 8'hc0 | {3'b0, c[10:6]};
			b[15:8] = 8'h80 | {2'b0, c[5:0]};
		end else if (c < 21'h10000) begin
			n = 3'd3;
			b[7:0]   = 8'he0 | {4'b0, c[15:12]};
			b[15:8]  = 8'h80 | {2'b0, c[11:6]};
			b[23:16] = 8'h80 | {2'b0, c[5:0]};
		end else begin
			n = 3'd4;
			b[7:0]   = 8'hf0 | {5'b0, c[20:18]};
			b[15:8]  = 8'h80 | {2'b0, c[17:12]};
			b[23:16] = 8'h80 | {2'b0, c[11:6]};
			b[31:24] = 8'h80 | {2'b0, c[5:0]};
		end
		return {n, b};
	endfunction

endpackage

FILE: hw/rtl/clsu_front.sv
// ----------------------------------------------------------------------------
// Command line splitter front end
// Pairs surrogates, runs the splitting rules and forms at most one op per word.
// ----------------------------------------------------------------------------
module clsu_front import clsu_pkg::*; #(
	parameter int ARGS_LIMIT = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	output logic        op_valid,
	input  logic        op_ready,
	output op_t         op
);

	typedef enum logic [3:0] {
		M_OUT, M_UNQ, M_QUO, M_BS_UNQ, M_BS_QUO, M_QEXIT, M_FIRST, M_FIRST_UNQ,
		M_FIRST_QUO
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [RUN_W-1:0] run;
		logic [14:0]      total;
		logic             run_en;
		logic [RUN_W-1:0] run_out;
		logic             enc;
		logic             arg_end;
	} step_t;

	localparam logic [14:0] TOT_MAX = 15'((ARGS_LIMIT > 32767) ? 32767 : ARGS_LIMIT);

	mode_t            mode_q;
	logic [RUN_W-1:0] run_q;
	logic [9:0]       hs_q;
	logic             held_q;
	logic [14:0]      total_q;
	logic             op_valid_q;
	op_t              op_q;

	logic             take;
	logic             pair;
	logic             hi_unit;
	logic             eol;
	logic [20:0]      c1;
	logic [20:0]      c2;
	logic [34:0]      e1;
	logic [34:0]      e2;
	step_t            s1;
	step_t            s2;
	op_t              f_op;
	mode_t            f_m;
	logic [RUN_W-1:0] f_run;
	logic [14:0]      f_tot;
	logic             f_held;
	logic [9:0]       f_hs;
	logic             emit_any;

	assign in_ready = !op_valid_q || op_ready;
	assign take     = in_valid && in_ready;
	assign op_valid = op_valid_q;
	assign op       = op_q;

	function automatic step_t step_char(input mode_t md, input logic [RUN_W-1:0] rn,
			input logic [14:0] tot, input logic [20:0] c);
		step_t s;
		logic  ws;
		logic  done;
		s       = '0;
		s.mode  = md;
		s.run   = rn;
		s.total = tot;
		done    = 1'b0;
		ws      = (c == CH_TAB || c == CH_SPACE);
		if (md == M_BS_UNQ || md == M_BS_QUO) begin
			if (c == CH_BSLASH) begin
				if (rn != RUN_MAX) s.run = rn + 15'd1;
				done = 1'b1;
			end else begin
				s.mode = (md == M_BS_UNQ) ? M_UNQ : M_QUO;
				s.run  = '0;
				if (c == CH_QUOTE) begin
					s.run_out = rn >> 1;
					s.run_en  = rn[RUN_W-1:1] != '0;
					if (rn[0]) begin
						s.enc = 1'b1;
						done  = 1'b1;
					end
				end else begin
					s.run_out = rn;
					s.run_en  = 1'b1;
				end
			end
		end
		if (!done && s.mode == M_QEXIT) begin
			s.mode = M_UNQ;
			if (c == CH_QUOTE) begin
				s.enc = 1'b1;
				done  = 1'b1;
			end
		end
		if (!done) begin
			case (s.mode)
				M_UNQ: begin
					if (ws) begin
						s.arg_end = 1'b1;
						s.mode    = M_OUT;
					end else if (c == CH_QUOTE) begin
						s.mode = M_QUO;
					end else if (c == CH_BSLASH) begin
						s.run  = 15'd1;
						s.mode = M_BS_UNQ;
					end else begin
						s.enc = 1'b1;
					end
				end
				M_QUO: begin
					if (c == CH_QUOTE) begin
						s.mode = M_QEXIT;
					end else if (c == CH_BSLASH) begin
						s.run  = 15'd1;
						s.mode = M_BS_QUO;
					end else begin
						s.enc = 1'b1;
					end
				end
				M_FIRST: begin
					if (ws) begin
						s.arg_end = 1'b1;
						s.mode    = M_OUT;
					end else if (c == CH_QUOTE) begin
						s.mode = M_FIRST_QUO;
					end else begin
						s.mode = M_FIRST_UNQ;
						s.enc  = 1'b1;
					end
				end
				M_FIRST_UNQ: begin
					if (ws) begin
						s.arg_end = 1'b1;
						s.mode    = M_OUT;
					end else begin
						s.enc = 1'b1;
					end
				end
				M_FIRST_QUO: begin
					if (c == CH_QUOTE) begin
						s.arg_end = 1'b1;
						s.mode    = M_OUT;
					end else begin
						s.enc = 1'b1;
					end
				end
				M_OUT: begin
					if (!ws) begin
						if (tot < TOT_MAX) s.total = tot + 15'd1;
						if (c == CH_QUOTE) begin
							s.mode = M_QUO;
						end else if (c == CH_BSLASH) begin
							s.run  = 15'd1;
							s.mode = M_BS_UNQ;
						end else begin
							s.mode = M_UNQ;
							s.enc  = 1'b1;
						end
					end
				end
				default: begin
					s.mode = M_OUT;
				end
			endcase
		end
		return s;
	endfunction

	assign pair    = held_q && code_unit[15:10] == SUR_LO;
	assign hi_unit = code_unit[15:10] == SUR_HI;
	assign eol     = code_unit == 16'h0000;
	assign c1      = pair ? (21'h10000 + {1'b0, hs_q, code_unit[9:0]}) : {5'b0, SUR_HI, hs_q};
	assign c2      = {5'b0, code_unit};
	assign e1      = utf8_encode(c1);
	assign e2      = utf8_encode(c2);

	always_comb begin
		s1       = '0;
		s1.mode  = mode_q;
		s1.run   = run_q;
		s1.total = total_q;
		if (held_q) s1 = step_char(mode_q, run_q, total_q, c1);
		s2         = s1;
		s2.run_en  = 1'b0;
		s2.run_out = '0;
		s2.enc     = 1'b0;
		s2.arg_end = 1'b0;
		if (!pair && !eol && !hi_unit) s2 = step_char(s1.mode, s1.run, s1.total, c2);

		f_op = '0;
		if (s1.run_en) begin
			f_op.run_en = 1'b1;
			f_op.run    = s1.run_out;
		end
		if (s2.run_en) begin
			f_op.run_en = 1'b1;
			f_op.run    = s2.run_out;
		end
		if (s1.enc) begin
			f_op.nbytes      = e1[34:32];
			f_op.bytes[31:0] = e1[31:0];
		end
		if (s2.enc) begin
			if (s1.enc) begin
				f_op.nbytes       = e1[34:32] + e2[34:32];
				f_op.bytes[47:24] = e2[23:0];
			end else begin
				f_op.nbytes      = e2[34:32];
				f_op.bytes[23:0] = e2[23:0];
			end
		end
		f_op.arg_end = s2.arg_end;
		f_m    = s2.mode;
		f_run  = s2.run;
		f_tot  = s2.total;
		f_held = !pair && hi_unit;
		f_hs   = f_held ? code_unit[9:0] : 10'd0;
		if (eol) begin
			if (s1.mode == M_BS_UNQ || s1.mode == M_BS_QUO) begin
				f_op.run_en = 1'b1;
				f_op.run    = s1.run;
			end
			f_op.arg_end  = s1.mode != M_OUT;
			f_op.line_end = 1'b1;
			f_op.count    = s1.total;
			f_m    = M_FIRST;
			f_run  = '0;
			f_tot  = 15'd1;
			f_held = 1'b0;
			f_hs   = '0;
		end
	end

	assign emit_any = f_op.run_en || f_op.nbytes != 3'd0 || f_op.arg_end || f_op.line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_FIRST;
			run_q      <= '0;
			hs_q       <= '0;
			held_q     <= 1'b0;
			total_q    <= 15'd1;
			op_valid_q <= 1'b0;
			op_q       <= '0;
		end else begin
			if (take) begin
				mode_q     <= f_m;
				run_q      <= f_run;
				total_q    <= f_tot;
				held_q     <= f_held;
				hs_q       <= f_hs;
				op_valid_q <= emit_any;
				op_q       <= f_op;
			end else if (op_ready) begin
				op_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		op_valid_q && op_q.line_end |-> op_q.count != '0)
		else $error("line end with zero count");
	assert property (@(posedge clk) disable iff (!arst_n)
		op_valid_q && op_q.run_en |-> op_q.run != '0)
		else $error("empty backslash run queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		op_valid_q |-> op_q.nbytes <= 3'd6)
		else $error("too many bytes in one op");
	assert property (@(posedge clk) disable iff (!arst_n)
		op_valid_q && !op_ready |=> op_valid_q && $stable(op_q))
		else $error("op changed while stalled");

endmodule

FILE: hw/rtl/clsu_back.sv
// ----------------------------------------------------------------------------
// Command line splitter back end
// Holds a short op queue and expands each op into results, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module clsu_back import clsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  op_t         op,
	input  logic        op_last,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int DEPTH = 4;

	typedef struct packed {
		op_t  o;
		logic lst;
	} ent_t;

	ent_t       mem_q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [3:0] pos_q;
	logic       out_v_q;
	res_t       out_q;

	ent_t       hd;
	logic [3:0] nres;
	logic [3:0] idx;
	res_t       cur;
	logic       adv;
	logic       pop;

	assign op_ready  = cnt_q != 3'(DEPTH);
	assign hd        = mem_q[rp_q];
	assign nres      = {3'b0, hd.o.run_en} + {1'b0, hd.o.nbytes} + {3'b0, hd.o.arg_end}
		+ {3'b0, hd.o.line_end};
	assign res_valid = out_v_q;
	assign res       = out_q;
	assign adv       = cnt_q != '0 && (!out_v_q || res_ready);
	assign pop       = adv && (pos_q + 4'd1 == nres);

	always_comb begin
		cur = '0;
		idx = pos_q;
		if (hd.o.run_en) begin
			if (idx == 4'd0) begin
				cur.data_byte = 8'h5c;
				cur.repeat_res = hd.o.run;
			end
			idx = idx - 4'd1;
		end
		if (!(hd.o.run_en && pos_q == 4'd0)) begin
			if (idx < {1'b0, hd.o.nbytes}) begin
				cur.data_byte  = hd.o.bytes[{idx[2:0], 3'b000} +: 8];
				cur.repeat_res = 15'd1;
			end else if (idx == {1'b0, hd.o.nbytes} && hd.o.arg_end) begin
				cur.kind = KIND_ARG;
			end else begin
				cur.kind = KIND_LINE;
				cur.arg_count = hd.o.count;
			end
		end
		cur.last = hd.lst && (pos_q + 4'd1 == nres);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (op_valid && op_ready) begin
				mem_q[wp_q] <= '{o: op, lst: op_last};
				wp_q <= wp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(op_valid && op_ready) - 3'(pop);
			if (adv) begin
				out_v_q <= 1'b1;
				out_q   <= cur;
				pos_q   <= pop ? 4'd0 : pos_q + 4'd1;
				if (pop) rp_q <= rp_q + 2'd1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(DEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> pos_q < nres)
		else $error("result index past op end");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.kind == KIND_LINE |-> out_q.last)
		else $error("line end not last");

endmodule

FILE: hw/rtl/command_line_splitter_utf16_to_utf8.sv
// ----------------------------------------------------------------------------
// Command line splitter, UTF-16 to WTF-8
// Splits a command line into arguments and sends WTF-8 byte results.
// ----------------------------------------------------------------------------
// One word is taken per cycle, surrogates included, unless the front end
// holds an op that the full op queue cannot take. The back end sends one
// result per cycle while the output is not stalled. A word makes one to
// three results for most characters, four for a surrogate pair, up to seven
// when an unpaired high surrogate is sent together with the following
// character, and none when it makes no op. The first result of a word passes
// through the front op register, the op queue and the output register. A
// stalled output holds in_ready low only once the queue has filled.
module command_line_splitter_utf16_to_utf8 import clsu_pkg::*; #(
	parameter int LINE_UNITS_MAX = 32767,
	parameter int ARGS_MAX = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [14:0] repeat_res,
	output logic [14:0] arg_count,
	output logic        last
);

	logic f_valid, f_ready, f_in_ready;
	op_t  f_op;
	res_t r;

	clsu_front #(.ARGS_LIMIT(ARGS_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(f_in_ready),
		.code_unit(code_unit), .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	assign in_ready = f_in_ready && (LINE_UNITS_MAX > 0);

	clsu_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(f_valid), .op_ready(f_ready), .op(f_op),
		.op_last(1'b1), .res_valid(out_valid), .res_ready(out_ready), .res(r)
	);

	assign kind       = r.kind;
	assign data_byte  = r.data_byte;
	assign repeat_res = r.repeat_res;
	assign arg_count  = r.arg_count;
	assign last       = r.last;

endmodule
